@@ rtl/lowest_free_id_allocator_macros.svh @@
// ----------------------------------------------------------------------------
// Lowest free id allocator: assertion macros
// Concurrent assertion wrappers clocked on clk_i; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef LOWEST_FREE_ID_ALLOCATOR_MACROS_SVH
`define LOWEST_FREE_ID_ALLOCATOR_MACROS_SVH

`ifndef SYNTH
// Checked outside reset only.
`define LFIA_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Checked at every edge, during reset too.
`define LFIA_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define LFIA_ASSERT(name, prop, msg)
`define LFIA_ASSERT_ALWAYS(name, prop, msg)
`endif

`endif

@@ rtl/lfia_pkg.sv @@
// ----------------------------------------------------------------------------
// Lowest free id allocator: package
// Shared widths, reset values, codes, controller states and the command and
// status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package lfia_pkg;

  localparam int unsigned ID_W        = 13;
  localparam int unsigned HIGH_W      = 14;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned WORD_BITS   = 64;
  localparam int unsigned BIT_W       = 6;
  localparam int unsigned GRANT_LIMIT = 8192;

  localparam logic [ID_W-1:0]   LOW_ID_RESET  = 13'd300;
  localparam logic [HIGH_W-1:0] HIGH_ID_RESET = 14'd5000;

  // Request opcodes.
  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_ALLOC = 2'd2;

  // Configuration register indexes.
  localparam logic CFG_LOW_ID  = 1'b0;
  localparam logic CFG_HIGH_ID = 1'b1;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ALLOC_RD,
    S_ALLOC_CHK,
    S_ALLOC_SET,
    S_REL_RD,
    S_REL_CHK
  } state_e;

  typedef struct packed {
    logic load;       // latch the request and the first word pointer
    logic clear_wr;   // write a zero word and advance the pointer
    logic rd;         // read the word at the pointer
    logic step;       // advance the pointer to the next word
    logic grab;       // register the lowest byte holding a free id
    logic set_wr;     // mark the chosen id allocated, report success
    logic rel_wr;     // free the requested id, report success
    logic fail_full;  // report that no id is free
    logic fail_rel;   // report that the id was not allocated
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic win_empty;
    logic rel_in_range;
    logic hit;
    logic last_word;
    logic rel_bit;
  } sts_t;

endpackage

@@ rtl/lowest_free_id_allocator.sv @@
// Allocate: scans the bitmap word by word from the word of low_id (read in ALLOC_RD,
//   checked in ALLOC_CHK), marks a grant in ALLOC_SET; an empty window fails without a read.
// Release: REL_RD reads the word and REL_CHK frees the bit; an id out of the window fails in REL_RD.
// One request at a time; busy is high from acceptance until done_o, and the next
//   request can be taken in the cycle of done_o. The bitmap accesses set the pace.
// Reset: asynchronous; a clearing pass writes one word a cycle, 128 words by default.
// ----------------------------------------------------------------------------
// Lowest free id allocator: top level
// Hands out the lowest free identifier of a configured window and takes back
// released ones, keeping a bitmap of allocated identifiers.
// ----------------------------------------------------------------------------
`include "lowest_free_id_allocator_macros.svh"

module lowest_free_id_allocator #(
  parameter int unsigned ID_SPACE = 8192
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic                               opcode_i,
  input  logic [lfia_pkg::ID_W-1:0]          release_id_i,
  output logic                               done_o,
  output logic [lfia_pkg::STATUS_W-1:0]      status_o,
  output logic [lfia_pkg::ID_W-1:0]          granted_id_o,
  input  logic                               cfg_we_i,
  input  logic                               cfg_idx_i,
  input  logic [lfia_pkg::HIGH_W-1:0]        cfg_wdata_i
);

  lfia_pkg::cmd_t cmd;
  lfia_pkg::sts_t sts;

  lfia_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .opcode_i (opcode_i),
    .sts_i    (sts),
    .cmd_o    (cmd),
    .busy     (busy)
  );

  lfia_dp #(
    .ID_SPACE (ID_SPACE)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .opcode_i     (opcode_i),
    .release_id_i (release_id_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .done_o       (done_o),
    .status_o     (status_o),
    .granted_id_o (granted_id_o)
  );

  // A result is only shown once the controller is free again.
  `LFIA_ASSERT(a_done_not_busy, done_o |-> !busy, "result shown while busy")
  // An accepted request keeps the block busy in the following cycle.
  `LFIA_ASSERT(a_start_busy, (start && !busy) |=> busy, "request not taken up")
  // A failed request never carries an identifier.
  `LFIA_ASSERT(a_fail_no_id, (done_o && status_o != lfia_pkg::ST_OK) |-> granted_id_o == '0,
               "identifier on a failed request")
  // At most one kind of bitmap write per cycle.
  `LFIA_ASSERT_ALWAYS(a_one_write, $onehot0({cmd.clear_wr, cmd.set_wr, cmd.rel_wr}),
                      "conflicting bitmap writes")

endmodule

@@ rtl/lfia_ctrl.sv @@
// ----------------------------------------------------------------------------
// Lowest free id allocator: controller
// Sequences the clearing pass, the word by word allocate scan and the
// read-modify-write of a release.
// ----------------------------------------------------------------------------
module lfia_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  input  logic            opcode_i,
  input  lfia_pkg::sts_t  sts_i,
  output lfia_pkg::cmd_t  cmd_o,
  output logic            busy
);

  lfia_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lfia_pkg::S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy    = 1'b1;
    case (state_q)
      lfia_pkg::S_CLEAR: begin
        cmd_o.clear_wr = 1'b1;
        if (sts_i.clr_last) begin
          state_d = lfia_pkg::S_IDLE;
        end
      end
      lfia_pkg::S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd_o.load = 1'b1;
          state_d = (opcode_i == lfia_pkg::OP_RELEASE) ? lfia_pkg::S_REL_RD
                                                       : lfia_pkg::S_ALLOC_RD;
        end
      end
      lfia_pkg::S_ALLOC_RD: begin
        if (sts_i.win_empty) begin
          cmd_o.fail_full = 1'b1;
          state_d = lfia_pkg::S_IDLE;
        end else begin
          cmd_o.rd = 1'b1;
          state_d = lfia_pkg::S_ALLOC_CHK;
        end
      end
      lfia_pkg::S_ALLOC_CHK: begin
        cmd_o.grab = 1'b1;
        if (sts_i.hit) begin
          state_d = lfia_pkg::S_ALLOC_SET;
        end else if (sts_i.last_word) begin
          cmd_o.fail_full = 1'b1;
          state_d = lfia_pkg::S_IDLE;
        end else begin
          cmd_o.step = 1'b1;
          state_d = lfia_pkg::S_ALLOC_RD;
        end
      end
      lfia_pkg::S_ALLOC_SET: begin
        cmd_o.set_wr = 1'b1;
        state_d = lfia_pkg::S_IDLE;
      end
      lfia_pkg::S_REL_RD: begin
        if (!sts_i.rel_in_range) begin
          cmd_o.fail_rel = 1'b1;
          state_d = lfia_pkg::S_IDLE;
        end else begin
          cmd_o.rd = 1'b1;
          state_d = lfia_pkg::S_REL_CHK;
        end
      end
      lfia_pkg::S_REL_CHK: begin
        if (sts_i.rel_bit) begin
          cmd_o.rel_wr = 1'b1;
        end else begin
          cmd_o.fail_rel = 1'b1;
        end
        state_d = lfia_pkg::S_IDLE;
      end
      default: begin
        state_d = lfia_pkg::S_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/lfia_dp.sv @@
// ----------------------------------------------------------------------------
// Lowest free id allocator: datapath
// Configuration registers, the allocation bitmap held as 64-bit words, the
// free-bit search and the result registers.
// ----------------------------------------------------------------------------
module lfia_dp #(
  parameter int unsigned ID_SPACE = 8192
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  lfia_pkg::cmd_t                     cmd_i,
  output lfia_pkg::sts_t                     sts_o,
  input  logic                               opcode_i,
  input  logic [lfia_pkg::ID_W-1:0]          release_id_i,
  input  logic                               cfg_we_i,
  input  logic                               cfg_idx_i,
  input  logic [lfia_pkg::HIGH_W-1:0]        cfg_wdata_i,
  output logic                               done_o,
  output logic [lfia_pkg::STATUS_W-1:0]      status_o,
  output logic [lfia_pkg::ID_W-1:0]          granted_id_o
);

  localparam int unsigned MAP_BITS  = (ID_SPACE < lfia_pkg::GRANT_LIMIT) ?
                                      ID_SPACE : lfia_pkg::GRANT_LIMIT;
  localparam int unsigned WORDS     = (MAP_BITS + lfia_pkg::WORD_BITS - 1) /
                                      lfia_pkg::WORD_BITS;
  localparam int unsigned WAW       = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam logic [WAW-1:0] LAST_PTR = WAW'(WORDS - 1);
  localparam logic [lfia_pkg::HIGH_W-1:0] MAP_TOP = lfia_pkg::HIGH_W'(MAP_BITS);

  localparam int unsigned WB = lfia_pkg::WORD_BITS;
  localparam int unsigned BW = lfia_pkg::BIT_W;

  logic [WB-1:0] mem [WORDS];

  logic [lfia_pkg::ID_W-1:0]   low_q;
  logic [lfia_pkg::HIGH_W-1:0] high_q;
  logic [WAW-1:0]              ptr_q, ptr_d;
  logic [lfia_pkg::ID_W-1:0]   rid_q;
  logic [WB-1:0]               rdata_q;
  logic [7:0]                  byte_q;
  logic [2:0]                  bidx_q;
  logic                        done_q;
  logic [lfia_pkg::STATUS_W-1:0] status_q;
  logic [lfia_pkg::ID_W-1:0]   granted_q;

  logic [lfia_pkg::HIGH_W-1:0] top_w;
  logic [lfia_pkg::ID_W-1:0]   last_id;
  logic [WAW-1:0]              low_word;
  logic [WAW-1:0]              last_word;
  logic [WB-1:0]               lo_mask, hi_mask, avail;
  logic [7:0]                  byte_any;
  logic [7:0]                  byte_pick;
  logic [2:0]                  byte_idx;
  logic [2:0]                  bit_pick;
  logic                        wr_en;
  logic [WB-1:0]               wr_data;
  logic [lfia_pkg::ID_W-1:0]   grant_id;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q  <= lfia_pkg::LOW_ID_RESET;
      high_q <= lfia_pkg::HIGH_ID_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        lfia_pkg::CFG_LOW_ID:  low_q  <= cfg_wdata_i[lfia_pkg::ID_W-1:0];
        lfia_pkg::CFG_HIGH_ID: high_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Window limits: the usable top never exceeds the stored map.
  assign top_w     = (high_q > MAP_TOP) ? MAP_TOP : high_q;
  assign last_id   = lfia_pkg::ID_W'(top_w - lfia_pkg::HIGH_W'(1));
  assign low_word  = low_q[BW +: WAW];
  assign last_word = last_id[BW +: WAW];

  // Only the first and last words of the window are partly outside it.
  assign lo_mask = (ptr_q == low_word) ? ({WB{1'b1}} << low_q[BW-1:0]) : {WB{1'b1}};
  assign hi_mask = (ptr_q == last_word) ?
                   ({WB{1'b1}} >> (BW'(WB - 1) - last_id[BW-1:0])) : {WB{1'b1}};
  assign avail   = ~rdata_q & lo_mask & hi_mask;

  always_comb begin
    for (int g = 0; g < 8; g++) begin
      byte_any[g] = |avail[g*8 +: 8];
    end
    byte_idx  = '0;
    byte_pick = '0;
    for (int g = 7; g >= 0; g--) begin
      if (byte_any[g]) begin
        byte_idx  = 3'(g);
        byte_pick = avail[g*8 +: 8];
      end
    end
    bit_pick = '0;
    for (int b = 7; b >= 0; b--) begin
      if (byte_q[b]) begin
        bit_pick = 3'(b);
      end
    end
  end

  assign grant_id = (lfia_pkg::ID_W'(ptr_q) << BW) |
                    lfia_pkg::ID_W'({bidx_q, bit_pick});

  always_comb begin
    ptr_d = ptr_q;
    if (cmd_i.load) begin
      ptr_d = (opcode_i == lfia_pkg::OP_RELEASE) ? release_id_i[BW +: WAW] : low_word;
    end else if (cmd_i.clear_wr || cmd_i.step) begin
      ptr_d = ptr_q + WAW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q <= '0;
    end else begin
      ptr_q <= ptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rid_q <= release_id_i;
    end
    if (cmd_i.grab) begin
      byte_q <= byte_pick;
      bidx_q <= byte_idx;
    end
  end

  // Bitmap memory: one read and one write port, registered read data.
  assign wr_en = cmd_i.clear_wr | cmd_i.set_wr | cmd_i.rel_wr;

  always_comb begin
    wr_data = '0;
    if (cmd_i.set_wr) begin
      wr_data = rdata_q | (WB'(1) << {bidx_q, bit_pick});
    end else if (cmd_i.rel_wr) begin
      wr_data = rdata_q & ~(WB'(1) << rid_q[BW-1:0]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[ptr_q] <= wr_data;
    end
    if (cmd_i.rd) begin
      rdata_q <= mem[ptr_q];
    end
  end

  // Result registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.set_wr | cmd_i.rel_wr | cmd_i.fail_full | cmd_i.fail_rel;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.set_wr || cmd_i.rel_wr) begin
      status_q <= lfia_pkg::ST_OK;
    end else if (cmd_i.fail_full) begin
      status_q <= lfia_pkg::ST_FULL;
    end else if (cmd_i.fail_rel) begin
      status_q <= lfia_pkg::ST_NOT_ALLOC;
    end
    if (cmd_i.set_wr) begin
      granted_q <= grant_id;
    end else if (cmd_i.rel_wr || cmd_i.fail_full || cmd_i.fail_rel) begin
      granted_q <= '0;
    end
  end

  assign done_o       = done_q;
  assign status_o     = status_q;
  assign granted_id_o = granted_q;

  assign sts_o.clr_last     = (ptr_q == LAST_PTR);
  assign sts_o.win_empty    = ({1'b0, low_q} >= top_w);
  assign sts_o.rel_in_range = (rid_q >= low_q) && ({1'b0, rid_q} < top_w);
  assign sts_o.hit          = |byte_any;
  assign sts_o.last_word    = (ptr_q == last_word);
  assign sts_o.rel_bit      = rdata_q[rid_q[BW-1:0]];

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lowest free id allocator: testbench
// Sends allocate and release requests through the start/busy handshake and
// rewrites the id window between phases. A bitmap model kept in the bench
// works out each result, and every done_o strobe is checked against it.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned MAP_SIZE     = 8192;
  localparam int unsigned CYCLE_LIMIT  = 2_000_000;
  localparam int unsigned RANDOM_ITEMS = 1700;
  localparam int unsigned QUIET_TAIL   = 250;

  typedef struct packed {
    logic [lfia_pkg::STATUS_W-1:0] status;
    logic [lfia_pkg::ID_W-1:0]     granted;
  } outcome_t;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          start;
  logic                          busy;
  logic                          opcode_i;
  logic [lfia_pkg::ID_W-1:0]     release_id_i;
  logic                          done_o;
  logic [lfia_pkg::STATUS_W-1:0] status_o;
  logic [lfia_pkg::ID_W-1:0]     granted_id_o;
  logic                          cfg_we_i;
  logic                          cfg_idx_i;
  logic [lfia_pkg::HIGH_W-1:0]   cfg_wdata_i;

  // Bench copy of the allocation bitmap and the window registers.
  bit                          id_taken [MAP_SIZE];
  logic [lfia_pkg::ID_W-1:0]   win_low;
  logic [lfia_pkg::HIGH_W-1:0] win_high;
  logic [lfia_pkg::ID_W-1:0]   held_ids [$];
  outcome_t                    pending_outcomes [$];

  int unsigned cycle_count = 0;
  int unsigned n_errors = 0;
  int unsigned n_requests = 0;
  int unsigned n_grants = 0;
  int unsigned n_exhausted = 0;
  int unsigned n_released = 0;
  int unsigned n_rejected = 0;
  int unsigned n_cfg_writes = 0;
  int unsigned idle_pct = 0;
  bit          quiet = 1'b0;

  lowest_free_id_allocator uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .opcode_i    (opcode_i),
    .release_id_i(release_id_i),
    .done_o      (done_o),
    .status_o    (status_o),
    .granted_id_o(granted_id_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding.",
               cycle_count, pending_outcomes.size());
      $display("lowest_free_id_allocator verification failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    if (n_errors < 50) begin
      $display("MISMATCH at %0t ns: %s", $time, msg);
    end
    n_errors++;
  endtask

  // The window ends at high_id, but never beyond the bitmap.
  function automatic int unsigned usable_top();
    return (win_high > MAP_SIZE) ? MAP_SIZE : int'(win_high);
  endfunction

  function automatic outcome_t predict_request(input logic op,
                                               input logic [lfia_pkg::ID_W-1:0] rid);
    outcome_t    res;
    int unsigned top;
    top = usable_top();
    res.status  = lfia_pkg::ST_NOT_ALLOC;
    res.granted = '0;
    n_requests++;
    if (op == lfia_pkg::OP_ALLOC) begin
      res.status = lfia_pkg::ST_FULL;
      for (int unsigned id = win_low; id < top; id++) begin
        if (!id_taken[id]) begin
          id_taken[id] = 1'b1;
          res.status   = lfia_pkg::ST_OK;
          res.granted  = lfia_pkg::ID_W'(id);
          held_ids.push_back(lfia_pkg::ID_W'(id));
          break;
        end
      end
      if (res.status == lfia_pkg::ST_OK) n_grants++;
      else n_exhausted++;
    end else if (rid >= win_low && rid < top && id_taken[rid]) begin
      id_taken[rid] = 1'b0;
      res.status    = lfia_pkg::ST_OK;
      for (int i = 0; i < held_ids.size(); i++) begin
        if (held_ids[i] == rid) begin
          held_ids.delete(i);
          break;
        end
      end
      n_released++;
    end else begin
      n_rejected++;
    end
    return res;
  endfunction

  // Each result is on the ports for one cycle only, so it is taken as it comes.
  always @(posedge clk_i) begin
    outcome_t want;
    if (rst_ni && done_o) begin
      if (pending_outcomes.size() == 0) begin
        report_mismatch($sformatf("result with no request outstanding: status %0d id %0d",
                                  status_o, granted_id_o));
      end else begin
        want = pending_outcomes.pop_front();
        if (status_o !== want.status) begin
          report_mismatch($sformatf("status %0d, expected %0d", status_o, want.status));
        end
        if (granted_id_o !== want.granted) begin
          report_mismatch($sformatf("granted id %0d, expected %0d",
                                    granted_id_o, want.granted));
        end
      end
    end
  end

  // Start stays high until the request is taken, then drops while busy is
  // certainly high, so it is never lowered and raised in one step.
  task automatic send_request(input logic op, input logic [lfia_pkg::ID_W-1:0] rid);
    start        <= 1'b1;
    opcode_i     <= op;
    release_id_i <= rid;
    do @(posedge clk_i); while (busy !== 1'b0);
    pending_outcomes.push_back(predict_request(op, rid));
    start <= 1'b0;
    @(posedge clk_i);
    if (!quiet && $urandom_range(99) < idle_pct) begin
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
  endtask

  task automatic wait_idle();
    while (pending_outcomes.size() != 0 || busy !== 1'b0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_register(input logic idx, input logic [lfia_pkg::HIGH_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    if (idx == lfia_pkg::CFG_LOW_ID) win_low = value[lfia_pkg::ID_W-1:0];
    else win_high = value;
    n_cfg_writes++;
  endtask

  task automatic set_window(input logic [lfia_pkg::HIGH_W-1:0] low_val,
                            input logic [lfia_pkg::HIGH_W-1:0] high_val);
    wait_idle();
    write_register(lfia_pkg::CFG_LOW_ID, low_val);
    write_register(lfia_pkg::CFG_HIGH_ID, high_val);
  endtask

  // Reset window: lowest-first grants, reuse of a gap, releases outside it.
  task automatic test_default_window();
    idle_pct = 40;
    repeat (3) send_request(lfia_pkg::OP_ALLOC, '1);
    send_request(lfia_pkg::OP_RELEASE, 13'd301);
    send_request(lfia_pkg::OP_RELEASE, 13'd301);
    send_request(lfia_pkg::OP_ALLOC, '0);
    send_request(lfia_pkg::OP_RELEASE, 13'd299);
    send_request(lfia_pkg::OP_RELEASE, 13'd5000);
    send_request(lfia_pkg::OP_RELEASE, 13'd8191);
    send_request(lfia_pkg::OP_RELEASE, 13'd302);
  endtask

  task automatic test_window_extremes();
    // Low write with bit 13 set is masked; high beyond the map is clamped.
    set_window(14'h3FFF, 14'h3FFF);
    send_request(lfia_pkg::OP_ALLOC, '0);
    send_request(lfia_pkg::OP_ALLOC, '0);
    send_request(lfia_pkg::OP_RELEASE, 13'd8191);
    set_window(14'h2000, 14'd8192);
    send_request(lfia_pkg::OP_ALLOC, '1);
    send_request(lfia_pkg::OP_RELEASE, 13'd0);
    // Empty and inverted windows.
    set_window(14'd5, 14'd5);
    send_request(lfia_pkg::OP_ALLOC, '0);
    send_request(lfia_pkg::OP_RELEASE, 13'd5);
    set_window(14'd10, 14'd1);
    send_request(lfia_pkg::OP_ALLOC, '0);
    send_request(lfia_pkg::OP_RELEASE, 13'd3);
    // Id 300 is still held but now lies outside the window.
    set_window(14'd0, 14'd300);
    send_request(lfia_pkg::OP_RELEASE, 13'd300);
    send_request(lfia_pkg::OP_ALLOC, '0);
    // Window over the stale ids: they must be skipped, never granted twice.
    set_window(14'd298, 14'd303);
    repeat (4) send_request(lfia_pkg::OP_ALLOC, '0);
  endtask

  task automatic test_fill_and_drain();
    int unsigned               base;
    int unsigned               span;
    int unsigned               pick;
    logic [lfia_pkg::ID_W-1:0] owned [$];
    logic [lfia_pkg::ID_W-1:0] last_id;
    base     = $urandom_range(0, 8100);
    span     = $urandom_range(8, 24);
    idle_pct = 30;
    set_window(lfia_pkg::HIGH_W'(base), lfia_pkg::HIGH_W'(base + span));
    repeat (span + 2) send_request(lfia_pkg::OP_ALLOC, lfia_pkg::ID_W'($urandom));
    // Hold off the next request until every result is back.
    wait_idle();
    for (int unsigned id = base; id < base + span; id++) begin
      if (id_taken[id]) owned.push_back(lfia_pkg::ID_W'(id));
    end
    last_id = owned[0];
    while (owned.size() != 0) begin
      pick    = $urandom_range(owned.size() - 1);
      last_id = owned[pick];
      owned.delete(pick);
      send_request(lfia_pkg::OP_RELEASE, last_id);
    end
    send_request(lfia_pkg::OP_RELEASE, last_id);
  endtask

  task automatic test_random_traffic();
    int unsigned sent;
    int unsigned phase_len;
    int unsigned alloc_pct;
    int unsigned roll;
    int unsigned low_pick;
    int unsigned top;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      quiet    = (sent + QUIET_TAIL >= RANDOM_ITEMS);
      idle_pct = ($urandom_range(3) == 0) ? 0 : $urandom_range(10, 50);
      roll     = $urandom_range(99);
      low_pick = $urandom_range(0, 8191);
      if (roll < 55) begin
        set_window(lfia_pkg::HIGH_W'(low_pick | ($urandom_range(1) << 13)),
                   lfia_pkg::HIGH_W'(low_pick + $urandom_range(1, 48)));
      end else if (roll < 65) begin
        set_window(lfia_pkg::HIGH_W'(low_pick),
                   lfia_pkg::HIGH_W'($urandom_range(0, low_pick)));
      end else if (roll < 85) begin
        set_window(lfia_pkg::HIGH_W'($urandom_range(0, 1000)),
                   $urandom_range(1) ? lfia_pkg::HIGH_W'(MAP_SIZE)
                                     : lfia_pkg::HIGH_W'($urandom_range(4000, 16383)));
      end else begin
        set_window(lfia_pkg::HIGH_W'($urandom_range(8150, 8191)),
                   lfia_pkg::HIGH_W'($urandom_range(8180, 16383)));
      end
      phase_len = $urandom_range(20, 60);
      alloc_pct = $urandom_range(30, 80);
      repeat (phase_len) begin
        roll = $urandom_range(99);
        top  = usable_top();
        if (roll < alloc_pct) begin
          send_request(lfia_pkg::OP_ALLOC, lfia_pkg::ID_W'($urandom));
        end else if (roll < 90 && held_ids.size() != 0) begin
          send_request(lfia_pkg::OP_RELEASE, held_ids[$urandom_range(held_ids.size() - 1)]);
        end else begin
          case ($urandom_range(3))
            0: send_request(lfia_pkg::OP_RELEASE, lfia_pkg::ID_W'($urandom));
            1: send_request(lfia_pkg::OP_RELEASE, win_low - 1'b1);
            2: send_request(lfia_pkg::OP_RELEASE, lfia_pkg::ID_W'(top));
            default: begin
              if (top > win_low) begin
                send_request(lfia_pkg::OP_RELEASE,
                             lfia_pkg::ID_W'($urandom_range(win_low, top - 1)));
              end else begin
                send_request(lfia_pkg::OP_RELEASE, win_low);
              end
            end
          endcase
        end
        sent++;
      end
    end
  endtask

  initial begin
    rst_ni       <= 1'b0;
    start        <= 1'b0;
    opcode_i     <= lfia_pkg::OP_ALLOC;
    release_id_i <= '0;
    cfg_we_i     <= 1'b0;
    cfg_idx_i    <= lfia_pkg::CFG_LOW_ID;
    cfg_wdata_i  <= '0;
    win_low  = lfia_pkg::LOW_ID_RESET;
    win_high = lfia_pkg::HIGH_ID_RESET;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_default_window();
    test_window_extremes();
    test_fill_and_drain();
    test_random_traffic();

    wait_idle();
    repeat (300) @(posedge clk_i);
    $display("Ran %0d requests: %0d grants, %0d exhausted, %0d released, %0d rejected.",
             n_requests, n_grants, n_exhausted, n_released, n_rejected);
    $display("Made %0d register writes; %0d ids still held; %0d mismatches.",
             n_cfg_writes, held_ids.size(), n_errors);
    if (n_errors == 0) begin
      $display("lowest_free_id_allocator verification clean");
    end else begin
      $display("lowest_free_id_allocator verification failed");
    end
    $finish;
  end

endmodule
